// ----- rtl/assert_macros.svh -----
// assertion helpers, sampled on clk_i and disabled while rst_ni is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define SIS_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

`define SIS_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`define SIS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/sis_pkg.sv -----
package sis_pkg;

  localparam int CAPACITY_DEF = 64;
  localparam int ID_BITS_DEF  = 16;

  // fixed field widths
  localparam int OPCODE_W   = 2;
  localparam int ID_W       = 16;
  localparam int STATUS_W   = 2;
  localparam int COUNT_W    = 7;
  localparam int POS_W      = 6;
  localparam int OUT_DATA_W = 16;

  localparam logic [OPCODE_W-1:0] OP_ADD    = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_REMOVE = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_CLEAR  = 2'd2;

  localparam logic [STATUS_W-1:0] ST_DONE      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;

  typedef struct packed {
    logic eq;  // stored entry equals key
    logic lt;  // stored entry below key
  } sis_cmp_t;

  typedef struct packed {
    logic                valid;
    logic [STATUS_W-1:0] status;
  } sis_res_t;

endpackage

// ----- rtl/sorted_id_set.sv -----
// channel   | dir | tdata                          | tuser
// s_axis    | in  | [15:0] id_value                | [1:0] opcode
// m_axis    | out | [6:0] entry_count, [12:7] pos  | [1:0] status
//
// one transaction at a time; add and remove run a binary search over the
// memory (a read state and a compare state per step) and then move each
// displaced entry by one place, add then writing the new entry;
// clear, full and unused opcodes go straight to the response state
// the identifier store is a single-port-write memory and needs no clearing
// after reset; a finished result moves into the output register when that is free,
// so the next transaction can be taken while m_axis is stalled
`include "assert_macros.svh"

module sorted_id_set import sis_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF,
  parameter int ID_BITS  = ID_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [ID_W-1:0]       s_axis_tdata,   // [15:0] id_value
  input  logic [OPCODE_W-1:0]   s_axis_tuser,   // [1:0] opcode
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata,   // [6:0] entry_count, [12:7] position
  output logic [STATUS_W-1:0]   m_axis_tuser    // [1:0] status
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int AW = $clog2(CAPACITY);

  sis_res_t            res;
  logic                res_ready;
  logic [CW-1:0]       count;
  logic [AW-1:0]       pos;
  logic [ID_BITS-1:0]  key;
  sis_cmp_t            cmp;
  logic                mem_we;
  logic [AW-1:0]       mem_waddr;
  logic [ID_BITS-1:0]  mem_wdata;
  logic                mem_re;
  logic [AW-1:0]       mem_raddr;
  logic [ID_BITS-1:0]  mem_rdata;

  logic                out_valid_q;
  logic [STATUS_W-1:0] out_status_q;
  logic [COUNT_W-1:0]  out_count_q;
  logic [POS_W-1:0]    out_pos_q;
  logic [31:0]         count_ext;
  logic [31:0]         pos_ext;

  sis_seq #(
    .CAPACITY (CAPACITY),
    .ID_BITS  (ID_BITS),
    .CW       (CW),
    .AW       (AW)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .op_i        (s_axis_tuser),
    .id_i        (s_axis_tdata),
    .res_o       (res),
    .res_ready_i (res_ready),
    .count_o     (count),
    .pos_o       (pos),
    .key_o       (key),
    .cmp_i       (cmp),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  sis_cmp #(
    .WIDTH (ID_BITS)
  ) u_cmp (
    .key_i  (key),
    .data_i (mem_rdata),
    .res_o  (cmp)
  );

  sis_mem #(
    .DEPTH (CAPACITY),
    .WIDTH (ID_BITS),
    .AW    (AW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // output register takes a result when empty or being drained
  assign res_ready = !out_valid_q || m_axis_tready;
  assign count_ext = 32'(count);
  assign pos_ext   = 32'(pos);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res.valid && res_ready) begin
      out_status_q <= res.status;
      out_count_q  <= count_ext[COUNT_W-1:0];
      out_pos_q    <= pos_ext[POS_W-1:0];
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_status_q;
  assign m_axis_tdata  = {(OUT_DATA_W - COUNT_W - POS_W)'(0), out_pos_q, out_count_q};

  `SIS_ASSERT(a_count_cap, count <= CW'(CAPACITY), "entry count above capacity")
  `SIS_ASSERT_IMPL(a_full_at_cap, res.valid && res.status == ST_FULL, count == CW'(CAPACITY), "full reported below capacity")
  `SIS_ASSERT_NEXT(a_busy_after_accept, s_axis_tvalid && s_axis_tready, !s_axis_tready, "new transaction taken while busy")
  `SIS_ASSERT_NEXT(a_result_lands, res.valid && res_ready, m_axis_tvalid, "result lost before output register")

endmodule

// ----- rtl/sis_mem.sv -----
module sis_mem import sis_pkg::*; #(
  parameter int DEPTH = CAPACITY_DEF,
  parameter int WIDTH = ID_BITS_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/sis_cmp.sv -----
module sis_cmp import sis_pkg::*; #(
  parameter int WIDTH = ID_BITS_DEF
) (
  input  logic [WIDTH-1:0] key_i,
  input  logic [WIDTH-1:0] data_i,
  output sis_cmp_t         res_o
);

  assign res_o.eq = (data_i == key_i);
  assign res_o.lt = (data_i < key_i);

endmodule

// ----- rtl/sis_seq.sv -----
module sis_seq import sis_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF,
  parameter int ID_BITS  = ID_BITS_DEF,
  parameter int CW       = $clog2(CAPACITY + 1),
  parameter int AW       = $clog2(CAPACITY)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [OPCODE_W-1:0] op_i,
  input  logic [ID_W-1:0]     id_i,
  output sis_res_t            res_o,
  input  logic                res_ready_i,
  output logic [CW-1:0]       count_o,
  output logic [AW-1:0]       pos_o,
  output logic [ID_BITS-1:0]  key_o,
  input  sis_cmp_t            cmp_i,
  output logic                mem_we_o,
  output logic [AW-1:0]       mem_waddr_o,
  output logic [ID_BITS-1:0]  mem_wdata_o,
  output logic                mem_re_o,
  output logic [AW-1:0]       mem_raddr_o,
  input  logic [ID_BITS-1:0]  mem_rdata_i
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_SRCH  = 6'b000010,
    S_CMP   = 6'b000100,
    S_SHIFT = 6'b001000,
    S_WNEW  = 6'b010000,
    S_RESP  = 6'b100000
  } sis_state_e;

  sis_state_e          state_q, state_d;
  logic [OPCODE_W-1:0] op_q, op_d;
  logic [ID_BITS-1:0]  key_q, key_d;
  logic [CW-1:0]       count_q, count_d;
  logic [CW-1:0]       lo_q, lo_d;
  logic [CW-1:0]       hx_q, hx_d;
  logic [AW-1:0]       mid_q, mid_d;
  logic [CW-1:0]       cur_q, cur_d;
  logic [CW-1:0]       n_q, n_d;
  logic                pend_q, pend_d;
  logic [AW-1:0]       wa_q, wa_d;
  logic [STATUS_W-1:0] status_q, status_d;
  logic [AW-1:0]       pos_q, pos_d;

  logic [31:0]         id_ext;
  logic [CW:0]         mid_sum;
  logic [CW:0]         mid_full;
  logic [AW-1:0]       mid_w;
  logic [CW-1:0]       mid_ext;
  logic [CW-1:0]       cur_p1;
  logic [CW-1:0]       cur_m1;
  logic                is_add;

  assign id_ext   = 32'(id_i);
  // midpoint of the half-open range [lo, hx), rounded down
  assign mid_sum  = {1'b0, lo_q} + {1'b0, hx_q} - (CW + 1)'(1);
  assign mid_full = mid_sum >> 1;
  assign mid_w    = mid_full[AW-1:0];
  assign mid_ext  = CW'(mid_q);
  assign cur_p1   = cur_q + CW'(1);
  assign cur_m1   = cur_q - CW'(1);
  assign is_add   = (op_q == OP_ADD);

  always_comb begin
    state_d  = state_q;
    op_d     = op_q;
    key_d    = key_q;
    count_d  = count_q;
    lo_d     = lo_q;
    hx_d     = hx_q;
    mid_d    = mid_q;
    cur_d    = cur_q;
    n_d      = n_q;
    pend_d   = pend_q;
    wa_d     = wa_q;
    status_d = status_q;
    pos_d    = pos_q;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          op_d     = op_i;
          key_d    = id_ext[ID_BITS-1:0];
          lo_d     = '0;
          hx_d     = count_q;
          pos_d    = '0;
          status_d = ST_DONE;
          pend_d   = 1'b0;
          case (op_i)
            OP_ADD: begin
              if (count_q >= CW'(CAPACITY)) begin
                status_d = ST_FULL;
                state_d  = S_RESP;
              end else begin
                state_d = S_SRCH;
              end
            end
            OP_REMOVE: state_d = S_SRCH;
            OP_CLEAR: begin
              count_d = '0;
              state_d = S_RESP;
            end
            default: state_d = S_RESP;
          endcase
        end
      end
      S_SRCH: begin
        if (lo_q < hx_q) begin
          mid_d   = mid_w;
          state_d = S_CMP;
        end else if (is_add) begin
          // insertion point found: move entries lo..count-1 up by one
          n_d     = count_q - lo_q;
          cur_d   = count_q - CW'(1);
          state_d = S_SHIFT;
        end else begin
          status_d = ST_NOT_FOUND;
          state_d  = S_RESP;
        end
      end
      S_CMP: begin
        if (!is_add && cmp_i.eq) begin
          // close the gap: move entries mid+1..count-1 down by one
          pos_d   = mid_q;
          n_d     = count_q - CW'(1) - mid_ext;
          cur_d   = mid_ext + CW'(1);
          state_d = S_SHIFT;
        end else begin
          if (cmp_i.lt || (is_add && cmp_i.eq)) begin
            lo_d = mid_ext + CW'(1);
          end else begin
            hx_d = mid_ext;
          end
          state_d = S_SRCH;
        end
      end
      S_SHIFT: begin
        if (n_q != '0) begin
          n_d    = n_q - CW'(1);
          pend_d = 1'b1;
          if (is_add) begin
            wa_d  = cur_p1[AW-1:0];
            cur_d = cur_m1;
          end else begin
            wa_d  = cur_m1[AW-1:0];
            cur_d = cur_p1;
          end
        end else begin
          pend_d = 1'b0;
          if (is_add) begin
            state_d = S_WNEW;
          end else begin
            count_d = count_q - CW'(1);
            state_d = S_RESP;
          end
        end
      end
      S_WNEW: begin
        count_d = count_q + CW'(1);
        pos_d   = lo_q[AW-1:0];
        state_d = S_RESP;
      end
      S_RESP: begin
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      pend_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      pend_q  <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q     <= op_d;
    key_q    <= key_d;
    lo_q     <= lo_d;
    hx_q     <= hx_d;
    mid_q    <= mid_d;
    cur_q    <= cur_d;
    n_q      <= n_d;
    wa_q     <= wa_d;
    status_q <= status_d;
    pos_q    <= pos_d;
  end

  // a shift step writes the entry read in the previous cycle
  assign mem_we_o    = (state_q == S_SHIFT && pend_q) || (state_q == S_WNEW);
  assign mem_waddr_o = (state_q == S_WNEW) ? lo_q[AW-1:0] : wa_q;
  assign mem_wdata_o = (state_q == S_WNEW) ? key_q : mem_rdata_i;
  assign mem_re_o    = (state_q == S_SRCH && lo_q < hx_q) ||
                       (state_q == S_SHIFT && n_q != '0);
  assign mem_raddr_o = (state_q == S_SRCH) ? mid_w : cur_q[AW-1:0];

  assign in_ready_o   = (state_q == S_IDLE);
  assign res_o.valid  = (state_q == S_RESP);
  assign res_o.status = status_q;
  assign count_o      = count_q;
  assign pos_o        = pos_q;
  assign key_o        = key_q;

endmodule

// ----- verif/tb_sorted_id_set.sv -----
module tb_sorted_id_set;
  import sis_pkg::*;

  localparam int CAP = CAPACITY_DEF;
  localparam logic [OPCODE_W-1:0] OP_NOP = 2'd3;
  localparam int RANDOM_OPS = 1900;
  localparam int PRINT_CAP = 100;

  typedef struct packed {
    logic [OPCODE_W-1:0] opcode;
    logic [ID_W-1:0]     id_value;
  } set_op_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [COUNT_W-1:0]  count;
    logic [POS_W-1:0]    pos;
  } set_result_t;

  typedef enum {MIX_FILL, MIX_DRAIN, MIX_EVEN} mix_e;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [ID_W-1:0]       s_axis_tdata = '0;   // [15:0] id_value
  logic [OPCODE_W-1:0]   s_axis_tuser = '0;   // [1:0] opcode
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;        // [6:0] entry_count, [12:7] position
  logic [STATUS_W-1:0]   m_axis_tuser;        // [1:0] status

  sorted_id_set uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #2 clk_i = ~clk_i;

  set_op_t     op_queue[$];
  set_result_t result_due_q[$];
  logic [ID_W-1:0] gen_held[$];   // multiset the generator expects to be held

  logic [ID_W-1:0] model_ids [CAP];
  int model_count = 0;

  int mismatches = 0;
  int results_seen = 0;
  bit op_taken = 1'b0;
  bit res_taken = 1'b0;
  int feed_gap = 0;
  int feed_calm = 0;
  int sink_wait = 0;
  int sink_calm = 0;

  task automatic report_mismatch(string what, int got, int want);
    mismatches++;
    if (mismatches <= PRINT_CAP)
      $display("result %0d: %s is %0d, expected %0d", results_seen, what, got, want);
  endtask

  // wait length for one transaction, with occasional stretches of no waiting
  function automatic int draw_wait(inout int calm);
    int n;
    if (calm > 0) begin
      calm--;
      n = 0;
    end else begin
      n = $urandom_range(0, 4);
      if ($urandom_range(0, 39) == 0) calm = $urandom_range(10, 60);
    end
    return n;
  endfunction

  function automatic set_result_t predict_set_update(logic [OPCODE_W-1:0] op,
                                                     logic [ID_W-1:0] id);
    set_result_t r;
    int ins;
    int lo;
    int hi;
    int mid;
    int hit;
    r.status = ST_DONE;
    r.pos = '0;
    case (op)
      OP_ADD: begin
        if (model_count >= CAP) begin
          r.status = ST_FULL;
        end else begin
          // goes after any equal entries
          ins = 0;
          while (ins < model_count && model_ids[ins] <= id) ins++;
          for (int k = model_count; k > ins; k--) model_ids[k] = model_ids[k-1];
          model_ids[ins] = id;
          model_count++;
          r.pos = ins[POS_W-1:0];
        end
      end
      OP_REMOVE: begin
        lo = 0;
        hi = model_count - 1;
        hit = -1;
        while (lo <= hi && hit < 0) begin
          mid = lo + (hi - lo) / 2;
          if (model_ids[mid] == id) hit = mid;
          else if (model_ids[mid] < id) lo = mid + 1;
          else hi = mid - 1;
        end
        if (hit < 0) begin
          r.status = ST_NOT_FOUND;
        end else begin
          for (int k = hit; k + 1 < model_count; k++) model_ids[k] = model_ids[k+1];
          model_count--;
          r.pos = hit[POS_W-1:0];
        end
      end
      OP_CLEAR: model_count = 0;
      default: ;
    endcase
    r.count = model_count[COUNT_W-1:0];
    return r;
  endfunction

  task automatic queue_op(logic [OPCODE_W-1:0] op, logic [ID_W-1:0] id);
    set_op_t t;
    int at;
    t.opcode = op;
    t.id_value = id;
    op_queue.insert(op_queue.size(), t);
    case (op)
      OP_ADD: if (gen_held.size() < CAP) gen_held.insert(gen_held.size(), id);
      OP_REMOVE: begin
        at = -1;
        foreach (gen_held[i]) if (at < 0 && gen_held[i] == id) at = i;
        if (at >= 0) gen_held.delete(at);
      end
      OP_CLEAR: gen_held.delete();
      default: ;
    endcase
  endtask

  // driver: transactions change at the falling edge
  always @(negedge clk_i) begin : feed
    logic vld;
    logic [ID_W-1:0] d;
    logic [OPCODE_W-1:0] u;
    set_op_t t;
    if (rst_ni) begin
      vld = s_axis_tvalid;
      d = s_axis_tdata;
      u = s_axis_tuser;
      if (op_taken) begin
        vld = 1'b0;
        op_taken = 1'b0;
      end
      if (!vld) begin
        if (feed_gap > 0) begin
          feed_gap--;
        end else if (op_queue.size() > 0) begin
          t = op_queue.pop_front();
          vld = 1'b1;
          d = t.id_value;
          u = t.opcode;
          feed_gap = draw_wait(feed_calm);
        end
      end
      s_axis_tvalid <= vld;
      s_axis_tdata <= d;
      s_axis_tuser <= u;
    end
  end

  // result side back-pressure
  always @(negedge clk_i) begin : drain
    logic rdy;
    if (rst_ni) begin
      if (res_taken) begin
        res_taken = 1'b0;
        sink_wait = draw_wait(sink_calm);
      end
      if (sink_wait > 0) begin
        rdy = 1'b0;
        sink_wait--;
      end else begin
        rdy = 1'b1;
      end
      m_axis_tready <= rdy;
    end
  end

  // monitor and predictor, both on the rising edge
  always @(posedge clk_i) begin : watch
    set_result_t want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        res_taken = 1'b1;
        if (result_due_q.size() == 0) begin
          report_mismatch("unexpected result, status", int'(m_axis_tuser), 0);
        end else begin
          want = result_due_q.pop_front();
          if (m_axis_tuser !== want.status)
            report_mismatch("status", int'(m_axis_tuser), int'(want.status));
          if (m_axis_tdata[6:0] !== want.count)
            report_mismatch("entry_count", int'(m_axis_tdata[6:0]), int'(want.count));
          if (m_axis_tdata[12:7] !== want.pos)
            report_mismatch("position", int'(m_axis_tdata[12:7]), int'(want.pos));
        end
        results_seen++;
      end
      if (s_axis_tvalid && s_axis_tready) begin
        op_taken = 1'b1;
        result_due_q.insert(result_due_q.size(),
                            predict_set_update(s_axis_tuser, s_axis_tdata));
      end
    end
  end

  initial begin : stimulus
    int made;
    int len;
    int r;
    bit narrow;
    mix_e mix;
    logic [OPCODE_W-1:0] op;
    logic [ID_W-1:0] id;

    // directed: empty set, extremes, duplicates, misses, clear, unused opcode
    queue_op(OP_REMOVE, 16'h1234);
    queue_op(OP_ADD, 16'h8000);
    queue_op(OP_ADD, 16'h0000);
    queue_op(OP_ADD, 16'hFFFF);
    queue_op(OP_ADD, 16'h8000);
    queue_op(OP_ADD, 16'h8000);
    queue_op(OP_ADD, 16'hAAAA);
    queue_op(OP_ADD, 16'h5555);
    queue_op(OP_REMOVE, 16'h8000);
    queue_op(OP_REMOVE, 16'h7FFF);
    queue_op(OP_NOP, 16'hFFFF);
    queue_op(OP_REMOVE, 16'h0000);
    queue_op(OP_REMOVE, 16'hFFFF);
    queue_op(OP_REMOVE, 16'hFFFF);
    queue_op(OP_CLEAR, 16'hFFFF);
    queue_op(OP_CLEAR, 16'h0000);
    queue_op(OP_NOP, 16'h0000);
    queue_op(OP_ADD, 16'h0001);
    queue_op(OP_ADD, 16'h0001);
    queue_op(OP_REMOVE, 16'h0001);
    queue_op(OP_REMOVE, 16'h0001);
    queue_op(OP_REMOVE, 16'h0001);

    // random phases: filling runs can reach the full set, narrow keys give duplicates
    made = 0;
    while (made < RANDOM_OPS) begin
      mix = mix_e'($urandom_range(0, 2));
      narrow = ($urandom_range(0, 3) == 0);
      len = $urandom_range(20, 140);
      for (int n = 0; n < len; n++) begin
        r = $urandom_range(0, 99);
        case (mix)
          MIX_FILL:  op = (r < 80) ? OP_ADD : OP_REMOVE;
          MIX_DRAIN: op = (r < 20) ? OP_ADD : OP_REMOVE;
          default:   op = (r < 50) ? OP_ADD : OP_REMOVE;
        endcase
        r = $urandom_range(0, 199);
        if (r == 0) op = OP_CLEAR;
        else if (r < 4) op = OP_NOP;
        if (narrow) id = ID_W'($urandom_range(0, 15));
        else id = ID_W'($urandom);
        r = $urandom_range(0, 19);
        if (r == 0) id = 16'h0000;
        else if (r == 1) id = 16'hFFFF;
        if (op == OP_REMOVE && gen_held.size() > 0 && $urandom_range(0, 3) != 0)
          id = gen_held[$urandom_range(0, gen_held.size() - 1)];
        queue_op(op, id);
        made++;
      end
    end

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (op_queue.size() > 0 || s_axis_tvalid || result_due_q.size() > 0)
      @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin : watchdog
    #4000000;
    $display("Mismatches found");
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/sis_pkg.sv
rtl/sis_mem.sv
rtl/sis_cmp.sv
rtl/sis_seq.sv
rtl/sorted_id_set.sv
verif/tb_sorted_id_set.sv
